@@ rtl/qfr_pkg.sv @@
package qfr_pkg;

  localparam int W      = 32;
  localparam int DATA_W = ((3 * W + 7) / 8) * 8;

  typedef logic signed [W-1:0] coef_t;

  typedef enum logic [1:0] {
    ST_REDUCED = 2'd0,
    ST_STEP    = 2'd1,
    ST_INVALID = 2'd2,
    ST_OVF     = 2'd3
  } status_t;

  // form carried alongside the arithmetic; done marks an item whose answer is settled
  typedef struct packed {
    coef_t   a;
    coef_t   b;
    coef_t   c;
    status_t st;
    logic    done;
  } ctx_t;

  typedef struct packed {
    coef_t p;
    coef_t q;
    coef_t z;
    ctx_t  ctx;
  } norm_in_t;

  typedef struct packed {
    coef_t p;
    coef_t qo;
    coef_t zo;
    logic  fits;
    ctx_t  ctx;
  } norm_out_t;

  // state handed from one divider cell to the next
  typedef struct packed {
    logic [W-1:0] rem;
    logic [W-1:0] dvd;
    logic [W-1:0] quo;
    logic [W-1:0] m;
    logic         neg;
    coef_t        p;
    coef_t        q;
    coef_t        z;
    ctx_t         ctx;
  } div_t;

endpackage

@@ rtl/qfr_cell.sv @@
module qfr_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  qfr_pkg::div_t in_d,
  output logic         out_valid,
  input  logic         out_ready,
  output qfr_pkg::div_t out_d
);
  import qfr_pkg::*;

  logic         v_r;
  div_t         d_r;
  div_t         d_nxt;
  logic [W:0]   t;
  logic [W:0]   diff;
  logic         ge;

  // one restoring quotient bit per cell, msb first
  always_comb begin
    t      = {in_d.rem, in_d.dvd[W-1]};
    diff   = t - {1'b0, in_d.m};
    ge     = (t >= {1'b0, in_d.m});
    d_nxt      = in_d;
    d_nxt.rem  = ge ? diff[W-1:0] : t[W-1:0];
    d_nxt.dvd  = {in_d.dvd[W-2:0], 1'b0};
    d_nxt.quo  = {in_d.quo[W-2:0], ge};
  end

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_d     = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule

@@ rtl/qfr_norm.sv @@
module qfr_norm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qfr_pkg::norm_in_t in_d,
  output logic              out_valid,
  input  logic              out_ready,
  output qfr_pkg::norm_out_t out_d
);
  import qfr_pkg::*;

  typedef struct packed {
    coef_t            p;
    coef_t            q;
    coef_t            z;
    logic [W-1:0]     t;
    logic signed [W:0] ks;
    ctx_t             ctx;
  } f_t;

  typedef struct packed {
    coef_t             p;
    coef_t             qo;
    coef_t             z;
    logic signed [W:0] ks;
    logic signed [W:0] h;
    ctx_t              ctx;
  } h_t;

  typedef struct packed {
    coef_t               p;
    coef_t               qo;
    coef_t               z;
    logic signed [2*W+1:0] prod;
    ctx_t                ctx;
  } x_t;

  // prep stage: |p - q| and the divisor 2p
  logic  p_v_r;
  div_t  p_d_r;
  div_t  p_d_nxt;
  logic  p_ready;
  logic  negq;

  always_comb begin
    negq          = (in_d.q > in_d.p);
    p_d_nxt.rem   = '0;
    p_d_nxt.dvd   = negq ? W'(in_d.q - in_d.p) : W'(in_d.p - in_d.q);
    p_d_nxt.quo   = '0;
    p_d_nxt.m     = {in_d.p[W-2:0], 1'b0};
    p_d_nxt.neg   = negq;
    p_d_nxt.p     = in_d.p;
    p_d_nxt.q     = in_d.q;
    p_d_nxt.z     = in_d.z;
    p_d_nxt.ctx   = in_d.ctx;
  end

  assign in_ready = !p_v_r || p_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (in_ready) begin
      p_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      p_d_r <= p_d_nxt;
    end
  end

  // divider chain
  logic cv [W+1];
  logic cr [W+1];
  div_t cd [W+1];

  assign cv[0]   = p_v_r;
  assign cd[0]   = p_d_r;
  assign p_ready = cr[0];

  for (genvar i = 0; i < W; i++) begin : g_cell
    qfr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (cv[i]),
      .in_ready (cr[i]),
      .in_d     (cd[i]),
      .out_valid(cv[i+1]),
      .out_ready(cr[i+1]),
      .out_d    (cd[i+1])
    );
  end

  // floor fix-up: a nonzero remainder on the negative side rounds the quotient away
  logic              f_v_r;
  f_t                f_d_r;
  f_t                f_d_nxt;
  logic              f_ready;
  logic signed [W:0] kx;

  always_comb begin
    kx           = {1'b0, cd[W].quo};
    f_d_nxt.p    = cd[W].p;
    f_d_nxt.q    = cd[W].q;
    f_d_nxt.z    = cd[W].z;
    f_d_nxt.ctx  = cd[W].ctx;
    if (!cd[W].neg) begin
      f_d_nxt.t  = cd[W].rem;
      f_d_nxt.ks = kx;
    end else if (cd[W].rem == '0) begin
      f_d_nxt.t  = '0;
      f_d_nxt.ks = -kx;
    end else begin
      f_d_nxt.t  = cd[W].m - cd[W].rem;
      f_d_nxt.ks = ~kx;
    end
  end

  assign cr[W] = !f_v_r || f_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (cr[W]) begin
      f_v_r <= cv[W];
    end
  end

  always_ff @(posedge clk) begin
    if (cr[W] && cv[W]) begin
      f_d_r <= f_d_nxt;
    end
  end

  // new middle coefficient and half the sum of old and new
  logic              h_v_r;
  h_t                h_d_r;
  h_t                h_d_nxt;
  logic              h_ready;
  logic signed [W:0] qw;
  logic signed [W:0] sw;

  always_comb begin
    qw          = {f_d_r.p[W-1], f_d_r.p} - {1'b0, f_d_r.t};
    sw          = {f_d_r.q[W-1], f_d_r.q} + qw;
    h_d_nxt.p   = f_d_r.p;
    h_d_nxt.qo  = qw[W-1:0];
    h_d_nxt.z   = f_d_r.z;
    h_d_nxt.ks  = f_d_r.ks;
    h_d_nxt.h   = sw >>> 1;
    h_d_nxt.ctx = f_d_r.ctx;
  end

  assign f_ready = !h_v_r || h_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
    end else if (f_ready) begin
      h_v_r <= f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f_ready && f_v_r) begin
      h_d_r <= h_d_nxt;
    end
  end

  // product k * h
  logic x_v_r;
  x_t   x_d_r;
  x_t   x_d_nxt;
  logic x_ready;

  always_comb begin
    x_d_nxt.p    = h_d_r.p;
    x_d_nxt.qo   = h_d_r.qo;
    x_d_nxt.z    = h_d_r.z;
    x_d_nxt.prod = h_d_r.ks * h_d_r.h;
    x_d_nxt.ctx  = h_d_r.ctx;
  end

  assign h_ready = !x_v_r || x_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_v_r <= 1'b0;
    end else if (h_ready) begin
      x_v_r <= h_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (h_ready && h_v_r) begin
      x_d_r <= x_d_nxt;
    end
  end

  // new constant coefficient and its range check
  logic                  z_v_r;
  norm_out_t             z_d_r;
  norm_out_t             z_d_nxt;
  logic signed [2*W+2:0] zw;

  always_comb begin
    zw           = (2*W+3)'(x_d_r.z) + (2*W+3)'(x_d_r.prod);
    z_d_nxt.p    = x_d_r.p;
    z_d_nxt.qo   = x_d_r.qo;
    z_d_nxt.zo   = zw[W-1:0];
    z_d_nxt.fits = (zw[2*W+2:W-1] == '0) || (zw[2*W+2:W-1] == '1);
    z_d_nxt.ctx  = x_d_r.ctx;
  end

  assign x_ready = !z_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_v_r <= 1'b0;
    end else if (x_ready) begin
      z_v_r <= x_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (x_ready && x_v_r) begin
      z_d_r <= z_d_nxt;
    end
  end

  assign out_valid = z_v_r;
  assign out_d     = z_d_r;

endmodule

@@ rtl/quadratic_form_reduction_step.sv @@
// One reduction step of a binary quadratic form (a, b, c) per stream beat.
// The form is first normalized so that -a < b <= a; if it is then reduced it is
// returned with status 0, otherwise one rho step gives (c, b', c') with status 1.
// Status 2 flags a leading coefficient below 1 (or c below 1 where a step is due),
// status 3 a constant coefficient that leaves the 32-bit range (all fields zero).
// Fully pipelined: one beat in and one beat out per cycle while out_tready is
// high. The pipeline is two 32-cell restoring divider chains (one quotient bit
// per cell), each followed by fix-up, multiply and add stages. Bubbles collapse, so
// a stalled output only blocks input once the whole pipeline is full.
module quadratic_form_reduction_step (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [qfr_pkg::DATA_W-1:0] in_tdata,   // in_a, in_b, in_c
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [qfr_pkg::DATA_W-1:0] out_tdata,  // out_a, out_b, out_c
  output logic [1:0]                out_tuser    // status
);
  import qfr_pkg::*;

  typedef struct packed {
    coef_t   a;
    coef_t   b;
    coef_t   c;
    status_t st;
  } res_t;

  // first pass: normalize (a, b, c)
  coef_t     ia;
  coef_t     ib;
  coef_t     ic;
  logic      inv;
  norm_in_t  n1_in;
  logic      n1_v;
  logic      n1_rdy;
  norm_out_t n1_out;

  always_comb begin
    ia  = in_tdata[W-1:0];
    ib  = in_tdata[2*W-1:W];
    ic  = in_tdata[3*W-1:2*W];
    inv = (ia < coef_t'(1));
    n1_in.p        = inv ? coef_t'(1) : ia;
    n1_in.q        = ib;
    n1_in.z        = ic;
    n1_in.ctx.a    = ia;
    n1_in.ctx.b    = ib;
    n1_in.ctx.c    = ic;
    n1_in.ctx.st   = ST_INVALID;
    n1_in.ctx.done = inv;
  end

  qfr_norm u_norm1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_d     (n1_in),
    .out_valid(n1_v),
    .out_ready(n1_rdy),
    .out_d    (n1_out)
  );

  // decide between reduced, invalid, overflow, or a rho step
  logic     d_v_r;
  norm_in_t d_d_r;
  norm_in_t d_d_nxt;
  logic     n2_rdy;

  always_comb begin
    d_d_nxt.ctx = n1_out.ctx;
    d_d_nxt.p   = coef_t'(1);
    d_d_nxt.q   = '0;
    d_d_nxt.z   = '0;
    if (n1_out.ctx.done) begin
      d_d_nxt.ctx = n1_out.ctx;
    end else if (!n1_out.fits) begin
      d_d_nxt.ctx = '{a: '0, b: '0, c: '0, st: ST_OVF, done: 1'b1};
    end else if ((n1_out.p < n1_out.zo) ||
                 ((n1_out.p == n1_out.zo) && (n1_out.qo >= 0))) begin
      d_d_nxt.ctx = '{a: n1_out.p, b: n1_out.qo, c: n1_out.zo, st: ST_REDUCED, done: 1'b1};
    end else if (n1_out.zo < coef_t'(1)) begin
      d_d_nxt.ctx = '{a: n1_out.p, b: n1_out.qo, c: n1_out.zo, st: ST_INVALID, done: 1'b1};
    end else begin
      // rho step is a normalization of (c, -b, a)
      d_d_nxt.ctx = '{a: n1_out.zo, b: '0, c: '0, st: ST_STEP, done: 1'b0};
      d_d_nxt.p   = n1_out.zo;
      d_d_nxt.q   = -n1_out.qo;
      d_d_nxt.z   = n1_out.p;
    end
  end

  assign n1_rdy = !d_v_r || n2_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (n1_rdy) begin
      d_v_r <= n1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (n1_rdy && n1_v) begin
      d_d_r <= d_d_nxt;
    end
  end

  // second pass
  logic      n2_v;
  logic      o_ready;
  norm_out_t n2_out;

  qfr_norm u_norm2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (d_v_r),
    .in_ready (n2_rdy),
    .in_d     (d_d_r),
    .out_valid(n2_v),
    .out_ready(o_ready),
    .out_d    (n2_out)
  );

  // output register
  logic o_v_r;
  res_t o_d_r;
  res_t o_d_nxt;

  always_comb begin
    if (n2_out.ctx.done) begin
      o_d_nxt = '{a: n2_out.ctx.a, b: n2_out.ctx.b, c: n2_out.ctx.c, st: n2_out.ctx.st};
    end else if (!n2_out.fits) begin
      o_d_nxt = '{a: '0, b: '0, c: '0, st: ST_OVF};
    end else begin
      o_d_nxt = '{a: n2_out.ctx.a, b: n2_out.qo, c: n2_out.zo, st: ST_STEP};
    end
  end

  assign o_ready = !o_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_ready) begin
      o_v_r <= n2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && n2_v) begin
      o_d_r <= o_d_nxt;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = DATA_W'({o_d_r.c, o_d_r.b, o_d_r.a});
  assign out_tuser  = o_d_r.st;

`ifndef SYNTH
  a_ovf_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (o_v_r && o_d_r.st == ST_OVF) |->
    (o_d_r.a == '0 && o_d_r.b == '0 && o_d_r.c == '0))
    else $error("overflow beat carries nonzero coefficients");

  a_step_lead : assert property (@(posedge clk) disable iff (!rst_n)
    (o_v_r && o_d_r.st == ST_STEP) |-> (o_d_r.a > 0))
    else $error("stepped form has nonpositive leading coefficient");

  a_mid_range : assert property (@(posedge clk) disable iff (!rst_n)
    (o_v_r && (o_d_r.st == ST_STEP || o_d_r.st == ST_REDUCED)) |->
    (o_d_r.b <= o_d_r.a && o_d_r.b > -o_d_r.a))
    else $error("middle coefficient outside (-a, a]");
`endif

endmodule
